@@ hw/rtl/slj_pkg.sv @@
package slj_pkg;

	localparam int MAX_COMPONENTS_DEF = 4;
	localparam int MAX_GROUP_DEF = 6;

	// config register indexes
	localparam logic [2:0] REG_FORMAT      = 3'd0;
	localparam logic [2:0] REG_FRAME_W     = 3'd1;
	localparam logic [2:0] REG_FRAME_H     = 3'd2;
	localparam logic [2:0] REG_SLICE_CNT   = 3'd3;
	localparam logic [2:0] REG_SLICE_W     = 3'd4;
	localparam logic [2:0] REG_LAST_W      = 3'd5;
	localparam logic [2:0] REG_IMAGE_SIZE  = 3'd6;
	localparam logic [2:0] REG_INIT_PRED   = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_GEOM = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [15:0] MAX_DX = 16'd19440;
	localparam logic [15:0] MAX_DY = 16'd5920;
	// floor(x/3) = (x * RECIP3) >> 17 for any 16-bit x
	localparam logic [16:0] RECIP3 = 17'd43691;
	// slice-row pixel position saturates here (above any real width)
	localparam logic [17:0] PIX_SAT = 18'h20000;

	typedef struct packed {
		logic [2:0] n;
		logic [1:0] xs;
		logic [1:0] ys;
		logic [2:0] g;
		logic [2:0] ppg;
		logic [2:0] step;
		logic [2:0] cpg;
		logic       sub;
	} fmt_t;

	typedef struct packed {
		fmt_t        fmt;
		logic        geom_ok;
		logic [15:0] rx;
		logic [16:0] ry;
		logic [15:0] ppsr_norm;
		logic [15:0] ppsr_last;
		logic [15:0] swc;
		logic [15:0] sw;
		logic [15:0] lsw;
		logic [7:0]  sc;
		logic [15:0] fw;
		logic [15:0] fh;
		logic        busy;
		logic        ld;
		logic [16:0] rem_ld;
		logic [17:0] pix_ld;
		logic        pred_ld;
		logic [63:0] pred_val;
	} geo_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [12:0] out_row;
		logic [14:0] out_col;
		logic [1:0]  status;
		logic        last;
	} res_t;

	function automatic fmt_t fmt_of(input logic [1:0] m);
		fmt_t f;
		case (m)
			2'd0: f = '{n: 3'd3, xs: 2'd2, ys: 2'd2, g: 3'd6, ppg: 3'd4, step: 3'd6,
				cpg: 3'd6, sub: 1'b1};
			2'd1: f = '{n: 3'd3, xs: 2'd2, ys: 2'd1, g: 3'd4, ppg: 3'd2, step: 3'd6,
				cpg: 3'd4, sub: 1'b1};
			2'd2: f = '{n: 3'd2, xs: 2'd1, ys: 2'd1, g: 3'd2, ppg: 3'd1, step: 3'd2,
				cpg: 3'd1, sub: 1'b0};
			default: f = '{n: 3'd4, xs: 2'd1, ys: 2'd1, g: 3'd4, ppg: 3'd1, step: 3'd4,
				cpg: 3'd1, sub: 1'b0};
		endcase
		return f;
	endfunction

endpackage

@@ hw/rtl/sliced_lossless_jpeg_reconstructor.sv @@
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-------------------------------------
// input     | in        | push / full               | difference[16:0] signed
// result    | out       | pop / empty               | sample, out_row, out_col, status, last
// config    | in        | cfg_we (no wait)          | cfg_index[2:0], cfg_data[63:0]
//
// One beat in and one beat out per cycle while neither side stalls and no geometry
// rebuild holds full high; a pushed beat is registered in the input queue, the engine
// computes its result from it and the result queue registers that result for popping
// (input queue -> sample engine -> result queue). After reset and after every config
// write, full stays high while the geometry check settles and the slice-row position
// is rebuilt by a 32-step divider followed by a 32-step shift-add multiplier.
// Reset clears the position, predictors and queues; the row-start store is
// undefined until written. Either side may stall; the two-entry queues keep
// the engine busy while a finished result waits.
module sliced_lossless_jpeg_reconstructor #(
	parameter int MAX_COMPONENTS = slj_pkg::MAX_COMPONENTS_DEF,
	parameter int MAX_GROUP      = slj_pkg::MAX_GROUP_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input queue side
	input  logic               push,
	output logic               full,
	input  logic signed [16:0] difference,
	// result queue side
	output logic               empty,
	input  logic               pop,
	output logic [15:0]        sample,
	output logic [12:0]        out_row,
	output logic [14:0]        out_col,
	output logic [1:0]         status,
	output logic               last,
	// config
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	slj_pkg::geo_t geo;
	slj_pkg::res_t res;
	slj_pkg::res_t out_data;

	logic        in_full;
	logic        in_empty;
	logic [16:0] in_diff;
	logic        out_full;
	logic        fire;
	logic [31:0] gfr;

	// front: input queue, blocked while geometry is being rebuilt
	assign full = in_full | geo.busy;

	slj_fifo #(.W(17)) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push & ~full),
		.wr_data (difference),
		.full    (in_full),
		.rd_en   (fire),
		.rd_data (in_diff),
		.empty   (in_empty)
	);

	slj_cfg #(
		.MAX_COMPONENTS (MAX_COMPONENTS),
		.MAX_GROUP      (MAX_GROUP)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.gfr       (gfr),
		.geo       (geo)
	);

	// engine takes one beat whenever the input queue holds one and the result queue has room
	assign fire = ~in_empty & ~out_full;

	slj_back #(
		.MAX_COMPONENTS (MAX_COMPONENTS),
		.MAX_GROUP      (MAX_GROUP)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.diff   (in_diff),
		.geo    (geo),
		.gfr    (gfr),
		.res    (res)
	);

	slj_fifo #(.W($bits(slj_pkg::res_t))) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fire),
		.wr_data (res),
		.full    (out_full),
		.rd_en   (pop & ~empty),
		.rd_data (out_data),
		.empty   (empty)
	);

	assign sample  = out_data.sample;
	assign out_row = out_data.out_row;
	assign out_col = out_data.out_col;
	assign status  = out_data.status;
	assign last    = out_data.last;

endmodule

@@ hw/rtl/slj_fifo.sv @@
module slj_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en)
				wp_q <= ~wp_q;
			if (rd_en)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wp_q] <= wr_data;
	end

	assign rd_data = mem_q[rp_q];
	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);

endmodule

@@ hw/rtl/slj_cfg.sv @@
module slj_cfg #(
	parameter int MAX_COMPONENTS = slj_pkg::MAX_COMPONENTS_DEF,
	parameter int MAX_GROUP      = slj_pkg::MAX_GROUP_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic [31:0]        gfr,
	output slj_pkg::geo_t      geo
);

	localparam logic [6:0] SEQ_START = 7'd8;
	localparam logic [6:0] DIV_END   = 7'd40;
	localparam logic [6:0] SEQ_LD    = 7'd72;
	localparam logic [6:0] SEQ_DONE  = 7'd73;

	logic [1:0]  mode_q;
	logic [15:0] fw_q, fh_q, sw_q, lsw_q;
	logic [7:0]  sc_q;
	logic [31:0] isz_q;
	logic [6:0]  cnt_q;

	slj_pkg::fmt_t fmt;
	logic [15:0] dx, dy;

	logic [31:0] dxh_prod_s1;
	logic [32:0] sw_prod_s1, lsw_prod_s1;
	logic [24:0] total_s1;

	logic [14:0] q6;
	logic [15:0] sw3, lsw3;
	logic        dxh_m3, sw_m3, lsw_m3;

	logic [15:0] rx_s2;
	logic [16:0] ry_s2;
	logic [40:0] lhs_s2;
	logic        dx_ok_s2, sw_ok_s2, lsw_ok_s2;
	logic [15:0] ppsr_norm_s2, ppsr_last_s2;

	logic [32:0] rxry_s3;
	logic [40:0] lhs_s3;
	logic        flags_s3;

	logic [34:0] rhs;
	logic        misc_ok;
	logic        ok_s4;

	logic [31:0] dvd_q;
	logic [16:0] drem_q;
	logic [17:0] acc_q;
	logic [17:0] rsh;
	logic [18:0] mac;
	logic [15:0] swc;

	function automatic logic div_ok(input logic [15:0] w, input logic m3,
		input logic [1:0] m);
		logic r;
		case (m)
			2'd0, 2'd1: r = !w[0] && m3;
			2'd2:       r = !w[0];
			default:    r = (w[1:0] == 2'd0);
		endcase
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd2;
			fw_q   <= 16'd1;
			fh_q   <= 16'd1;
			sc_q   <= 8'd1;
			sw_q   <= 16'd1;
			lsw_q  <= 16'd1;
			isz_q  <= 32'd65537;
		end else if (cfg_we) begin
			case (cfg_index)
				slj_pkg::REG_FORMAT:     mode_q <= cfg_data[1:0];
				slj_pkg::REG_FRAME_W:    fw_q   <= cfg_data[15:0];
				slj_pkg::REG_FRAME_H:    fh_q   <= cfg_data[15:0];
				slj_pkg::REG_SLICE_CNT:  sc_q   <= cfg_data[7:0];
				slj_pkg::REG_SLICE_W:    sw_q   <= cfg_data[15:0];
				slj_pkg::REG_LAST_W:     lsw_q  <= cfg_data[15:0];
				slj_pkg::REG_IMAGE_SIZE: isz_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign fmt = slj_pkg::fmt_of(mode_q);
	assign dx  = isz_q[15:0];
	assign dy  = isz_q[31:16];

	// stage 1: reciprocal products and total slice width
	always_ff @(posedge clk) begin
		dxh_prod_s1 <= 32'(dx[15:1]) * 32'(slj_pkg::RECIP3);
		sw_prod_s1  <= 33'(sw_q) * 33'(slj_pkg::RECIP3);
		lsw_prod_s1 <= 33'(lsw_q) * 33'(slj_pkg::RECIP3);
		total_s1    <= (sc_q == 8'd0) ? 25'd0
			: 25'(sc_q - 8'd1) * 25'(sw_q) + 25'(lsw_q);
	end

	assign q6     = dxh_prod_s1[31:17];
	assign sw3    = sw_prod_s1[32:17];
	assign lsw3   = lsw_prod_s1[32:17];
	assign dxh_m3 = (17'(dx[15:1]) == 17'(q6) * 17'd3);
	assign sw_m3  = (18'(sw_q) == 18'(sw3) * 18'd3);
	assign lsw_m3 = (18'(lsw_q) == 18'(lsw3) * 18'd3);

	// stage 2: raw dims, divisibility, frame area
	always_ff @(posedge clk) begin
		case (mode_q)
			2'd0:    rx_s2 <= {q6, 1'b0};
			2'd1:    rx_s2 <= {1'b0, dx[15:2], 1'b0};
			default: rx_s2 <= dx;
		endcase
		ry_s2  <= (fmt.ys == 2'd2) ? {dy, 1'b0} : {1'b0, dy};
		lhs_s2 <= 41'(fh_q) * 41'(total_s1);
		dx_ok_s2 <= (dx != 16'd0) && (dy != 16'd0) && (dx <= slj_pkg::MAX_DX)
			&& (dy <= slj_pkg::MAX_DY)
			&& ((mode_q == 2'd0) ? (!dx[0] && dxh_m3)
			: (mode_q == 2'd1) ? (dx[1:0] == 2'd0) : 1'b1);
		sw_ok_s2     <= div_ok(sw_q, sw_m3, mode_q);
		lsw_ok_s2    <= div_ok(lsw_q, lsw_m3, mode_q);
		ppsr_norm_s2 <= fmt.sub ? sw3 : sw_q;
		ppsr_last_s2 <= fmt.sub ? lsw3 : lsw_q;
	end

	// stage 3
	always_ff @(posedge clk) begin
		rxry_s3  <= 33'(rx_s2) * 33'(ry_s2);
		lhs_s3   <= lhs_s2;
		flags_s3 <= dx_ok_s2 && sw_ok_s2 && lsw_ok_s2 && (sw_q <= rx_s2)
			&& (lsw_q <= rx_s2);
	end

	assign rhs = fmt.sub ? (35'({rxry_s3, 1'b0}) + 35'(rxry_s3)) : 35'(rxry_s3);
	assign misc_ok = (int'(fmt.n) <= MAX_COMPONENTS) && (int'(fmt.g) <= MAX_GROUP)
		&& !((sc_q >= 8'd2) && (sw_q == 16'd0))
		&& !((sc_q >= 8'd1) && (lsw_q == 16'd0))
		&& ((fmt.ys != 2'd2) || !fh_q[0])
		&& (fw_q != 16'd0) && ((fmt.xs != 2'd2) || !fw_q[0]);

	// stage 4
	always_ff @(posedge clk) begin
		ok_s4 <= flags_s3 && !(lhs_s3 < 41'(rhs)) && misc_ok;
	end

	assign swc = (sc_q == 8'd1) ? ppsr_last_s2 : ppsr_norm_s2;

	// recompute sequencer: gfr / ry (32 steps), then quotient * swc (32 steps)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 7'd0;
		else if (cfg_we)
			cnt_q <= 7'd0;
		else if (cnt_q != SEQ_DONE)
			cnt_q <= cnt_q + 7'd1;
	end

	assign rsh = {drem_q, dvd_q[31]};
	assign mac = {acc_q, 1'b0} + (dvd_q[31] ? 19'(swc) : 19'd0);

	always_ff @(posedge clk) begin
		if (cnt_q == SEQ_START - 7'd1) begin
			dvd_q  <= gfr;
			drem_q <= 17'd0;
			acc_q  <= 18'd0;
		end else if (cnt_q >= SEQ_START && cnt_q < DIV_END) begin
			if (rsh >= {1'b0, ry_s2}) begin
				drem_q <= 17'(rsh - {1'b0, ry_s2});
				dvd_q  <= {dvd_q[30:0], 1'b1};
			end else begin
				drem_q <= rsh[16:0];
				dvd_q  <= {dvd_q[30:0], 1'b0};
			end
		end else if (cnt_q >= DIV_END && cnt_q < SEQ_LD) begin
			acc_q <= (mac >= 19'(slj_pkg::PIX_SAT)) ? slj_pkg::PIX_SAT : mac[17:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
	end

	always_comb begin
		geo.fmt       = fmt;
		geo.geom_ok   = ok_s4;
		geo.rx        = rx_s2;
		geo.ry        = ry_s2;
		geo.ppsr_norm = ppsr_norm_s2;
		geo.ppsr_last = ppsr_last_s2;
		geo.swc       = swc;
		geo.sw        = sw_q;
		geo.lsw       = lsw_q;
		geo.sc        = sc_q;
		geo.fw        = fw_q;
		geo.fh        = fh_q;
		geo.busy      = (cnt_q != SEQ_DONE);
		geo.ld        = (cnt_q == SEQ_LD);
		geo.rem_ld    = drem_q;
		geo.pix_ld    = acc_q;
		geo.pred_ld   = cfg_we && (cfg_index == slj_pkg::REG_INIT_PRED);
		geo.pred_val  = cfg_data;
	end

	a_ld_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		geo.ld && !cfg_we |=> !geo.busy)
		else $error("busy still set after position reload");
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> geo.busy && !geo.ld)
		else $error("config write did not restart recompute");

endmodule

@@ hw/rtl/slj_back.sv @@
module slj_back #(
	parameter int MAX_COMPONENTS = slj_pkg::MAX_COMPONENTS_DEF,
	parameter int MAX_GROUP      = slj_pkg::MAX_GROUP_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [16:0]         diff,
	input  slj_pkg::geo_t       geo,
	output logic [31:0]         gfr,
	output slj_pkg::res_t       res
);

	localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int GW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	logic [15:0] pred_q [MAX_COMPONENTS];
	logic [15:0] pred_n [MAX_COMPONENTS];
	logic [15:0] rsg_q  [MAX_GROUP];
	logic [7:0]  sidx_q, sidx_n;
	logic [15:0] srow_q, srow_n;
	logic [31:0] gfr_q, gfr_n;
	logic [15:0] fcol_q, fcol_n;
	logic [15:0] scol_q, scol_n;
	logic [12:0] irow_q, irow_n;
	logic [14:0] icol_q, icol_n;
	logic [2:0]  grp_q, grp_n;
	logic        fin_q, fin_n;
	logic [16:0] rem_q, rem_n;
	logic [17:0] pix_q, pix_n;

	logic [2:0]  gp;
	logic [15:0] smp;
	logic        rsg_we;

	slj_pkg::fmt_t fm;

	always_comb begin
		logic        run;
		logic        last_sl;
		logic [15:0] ppsr;
		logic [18:0] pend;
		logic [15:0] pshift;
		logic [12:0] irow;
		logic [14:0] icol;
		logic [15:0] fcol;
		logic [2:0]  comp;
		logic [CW-1:0] ci;
		logic [2:0]  gp1;
		logic [2:0]  ridx;
		logic [16:0] scn;
		logic [15:0] wof;
		logic [16:0] sr;
		logic [17:0] remt;
		logic [18:0] pixt;
		logic [15:0] predv [MAX_COMPONENTS];

		fm      = geo.fmt;
		gp      = (grp_q >= fm.g) ? 3'd0 : grp_q;
		pred_n  = pred_q;
		predv   = pred_q;
		sidx_n  = sidx_q;
		srow_n  = srow_q;
		gfr_n   = gfr_q;
		fcol_n  = fcol_q;
		scol_n  = scol_q;
		irow_n  = irow_q;
		icol_n  = icol_q;
		grp_n   = grp_q;
		fin_n   = fin_q;
		rem_n   = rem_q;
		pix_n   = pix_q;
		smp     = 16'd0;
		rsg_we  = 1'b0;
		res     = '0;
		run     = 1'b0;
		last_sl = (9'(sidx_q) + 9'd1 == 9'(geo.sc));
		ppsr    = last_sl ? geo.ppsr_last : geo.ppsr_norm;
		pend    = 19'(pix_q) + 19'(ppsr);
		pshift  = (fm.xs == 2'd2) ? {1'b0, pix_q[15:1]} : pix_q[15:0];
		irow    = irow_q;
		icol    = icol_q;
		fcol    = fcol_q;
		comp    = 3'd0;
		ci      = '0;
		gp1     = 3'd0;
		ridx    = 3'd0;
		scn     = 17'd0;
		wof     = 16'd0;
		sr      = 17'd0;
		remt    = 18'd0;
		pixt    = 19'd0;

		if (fin_q) begin
			res.status = slj_pkg::ST_DONE;
		end else if (!geo.geom_ok) begin
			res.status = slj_pkg::ST_GEOM;
		end else begin
			grp_n = gp;
			run   = 1'b1;
			// start of a slice row
			if (gp == 3'd0 && scol_q == 16'd0) begin
				if (sidx_q >= geo.sc || pix_q >= {2'b0, geo.rx}) begin
					fin_n      = 1'b1;
					res.status = slj_pkg::ST_DONE;
					run        = 1'b0;
				end else if (pend > 19'(geo.rx) || (last_sl && pend != 19'(geo.rx))) begin
					res.status = slj_pkg::ST_GEOM;
					run        = 1'b0;
				end else begin
					irow = 13'((fm.ys == 2'd2) ? (rem_q >> 1) : rem_q);
					icol = 15'(19'(pshift) * 19'(fm.cpg));
				end
			end

			if (run) begin
				// frame row boundary: reload from first group of previous row
				if (gp == 3'd0 && fcol_q >= geo.fw) begin
					for (int c = 0; c < MAX_COMPONENTS; c++) begin
						if (3'(c) < fm.n) begin
							ridx = (c == 0) ? 3'd0 : (fm.g - fm.n + 3'(c));
							predv[c] = rsg_q[ridx[GW-1:0]];
						end
					end
					fcol = 16'd0;
				end
				comp = (gp < fm.ppg) ? 3'd0 : (gp - fm.ppg + 3'd1);
				ci   = comp[CW-1:0];
				smp  = predv[ci] + diff[15:0];
				predv[ci] = smp;
				pred_n = predv;
				rsg_we = (fcol == 16'd0);

				res.sample  = smp;
				res.out_row = irow;
				res.out_col = icol + 15'(gp);
				irow_n = irow;
				icol_n = icol;
				fcol_n = fcol;

				gp1 = gp + 3'd1;
				if (gp1 >= fm.g) begin
					grp_n  = 3'd0;
					icol_n = icol + 15'(fm.g);
					fcol_n = fcol + 16'(fm.xs);
					scn    = 17'(scol_q) + 17'(fm.step);
					wof    = last_sl ? geo.lsw : geo.sw;
					if (scn >= 17'(wof)) begin
						scol_n = 16'd0;
						gfr_n  = gfr_q + 32'(fm.ys);
						sr     = 17'(srow_q) + 17'(fm.ys);
						if (sr >= 17'(geo.fh)) begin
							sr     = 17'd0;
							sidx_n = sidx_q + 8'd1;
						end
						srow_n = sr[15:0];
						remt   = 18'(rem_q) + 18'(fm.ys);
						if (remt >= 18'(geo.ry)) begin
							rem_n = 17'(remt - 18'(geo.ry));
							pixt  = 19'(pix_q) + 19'(geo.swc);
							pix_n = (pixt >= 19'(slj_pkg::PIX_SAT)) ? slj_pkg::PIX_SAT
								: pixt[17:0];
						end else begin
							rem_n = remt[16:0];
						end
						fin_n = (sidx_n >= geo.sc) || (pix_n >= {2'b0, geo.rx});
					end else begin
						scol_n = scn[15:0];
					end
				end else begin
					grp_n = gp1;
				end
				res.last = fin_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_COMPONENTS; c++)
				pred_q[c] <= 16'd0;
			sidx_q <= 8'd0;
			srow_q <= 16'd0;
			gfr_q  <= 32'd0;
			fcol_q <= 16'd0;
			scol_q <= 16'd0;
			irow_q <= 13'd0;
			icol_q <= 15'd0;
			grp_q  <= 3'd0;
			fin_q  <= 1'b0;
			rem_q  <= 17'd0;
			pix_q  <= 18'd0;
		end else begin
			if (fire) begin
				pred_q <= pred_n;
				sidx_q <= sidx_n;
				srow_q <= srow_n;
				gfr_q  <= gfr_n;
				fcol_q <= fcol_n;
				scol_q <= scol_n;
				irow_q <= irow_n;
				icol_q <= icol_n;
				grp_q  <= grp_n;
				fin_q  <= fin_n;
				rem_q  <= rem_n;
				pix_q  <= pix_n;
			end
			if (geo.ld) begin
				rem_q <= geo.rem_ld;
				pix_q <= geo.pix_ld;
			end
			if (geo.pred_ld) begin
				for (int c = 0; c < MAX_COMPONENTS; c++)
					pred_q[c] <= geo.pred_val[16*c +: 16];
			end
		end
	end

	// row-start store, no reset
	always_ff @(posedge clk) begin
		if (fire && rsg_we)
			rsg_q[gp[GW-1:0]] <= smp;
	end

	assign gfr = gfr_q;

	a_grp_range: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !fin_q && geo.geom_ok |=> grp_q < $past(geo.fmt.g))
		else $error("group position out of range");
	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q)
		else $error("finished flag cleared");
	a_last_fin: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.last |=> fin_q)
		else $error("last beat without completion");
	a_pix_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pix_q <= slj_pkg::PIX_SAT)
		else $error("slice-row pixel beyond saturation");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// ------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------
	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic signed [16:0] difference;
	logic               empty;
	logic               pop;
	logic [15:0]        sample;
	logic [12:0]        out_row;
	logic [14:0]        out_col;
	logic [1:0]         status;
	logic               last;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [63:0]        cfg_data;

	sliced_lossless_jpeg_reconstructor dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .difference(difference),
		.empty(empty), .pop(pop),
		.sample(sample), .out_row(out_row), .out_col(out_col),
		.status(status), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Stimulus table: config writes and difference beats. A row may carry
	// a hand-typed status (errors right after reset or after a bad write);
	// all other rows are checked against the sample predictor.
	// ------------------------------------------------------------------
	typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [2:0]         idx;
		logic [63:0]        data;
		logic signed [16:0] diff;
		bit                 typed;
		logic [1:0]         st;
	} stim_row_t;

	stim_row_t stim_tab[$];

	// idle pattern: 0 = sender 19% / receiver 86%, 1 = reverse, 2 = none
	int  idle_mode;
	bit  hold_go;
	bit  pin_typed;
	slj_pkg::res_t pin_res;
	int  errors = 0;

	// coverage tallies for the summary
	int  n_beats_in = 0;
	int  n_ok = 0;
	int  n_geom = 0;
	int  n_done = 0;
	int  n_last = 0;
	int  n_cfg = 0;

	// ------------------------------------------------------------------
	// Sample predictor: register copy plus position/predictor state
	// ------------------------------------------------------------------
	int unsigned r_format, r_fw, r_fh, r_slices, r_sw, r_lsw;
	logic [31:0] r_size;

	logic [15:0] pred_val [4];
	logic [15:0] row_first [6];
	int unsigned s_idx, s_row, s_col, f_col, g_pos;
	int unsigned gfr;
	logic [12:0] img_row;
	logic [14:0] img_col;
	bit          img_done;

	int unsigned fm_n, fm_xs, fm_ys, fm_g, fm_ppg, fm_cpp, fm_step, fm_cpg;
	bit          fm_sub;

	function automatic void load_fmt();
		case (r_format)
			0: begin fm_n = 3; fm_xs = 2; fm_ys = 2; end
			1: begin fm_n = 3; fm_xs = 2; fm_ys = 1; end
			2: begin fm_n = 2; fm_xs = 1; fm_ys = 1; end
			default: begin fm_n = 4; fm_xs = 1; fm_ys = 1; end
		endcase
		fm_sub  = (fm_xs != 1) || (fm_ys != 1);
		fm_ppg  = fm_xs * fm_ys;
		fm_g    = fm_sub ? 2 + fm_ppg : fm_n;
		fm_cpp  = fm_sub ? 3 : 1;
		fm_step = fm_n * fm_xs;
		fm_cpg  = fm_sub ? fm_g : 1;
	endfunction

	function automatic int unsigned slice_w(int unsigned id);
		return (id + 1 == r_slices) ? r_lsw : r_sw;
	endfunction

	function automatic longint unsigned pix_w();
		longint unsigned dx;
		dx = r_size[15:0];
		return fm_sub ? dx / fm_g * fm_xs : dx * fm_xs;
	endfunction

	function automatic longint unsigned pix_h();
		return longint'(r_size[31:16]) * fm_ys;
	endfunction

	function automatic bit width_fits(longint unsigned w, longint unsigned rx);
		return w <= rx && (w % fm_step) == 0 && (w % fm_cpp) == 0;
	endfunction

	function automatic bit geom_valid();
		longint unsigned dx, dy, rx, ry, total;
		dx = r_size[15:0];
		dy = r_size[31:16];
		if (fm_n > slj_pkg::MAX_COMPONENTS_DEF || fm_g > slj_pkg::MAX_GROUP_DEF) return 0;
		if (dx == 0 || dy == 0 || dx > slj_pkg::MAX_DX || dy > slj_pkg::MAX_DY) return 0;
		if (fm_sub && (dx % fm_g) != 0) return 0;
		if (r_slices >= 2 && r_sw == 0) return 0;
		if (r_slices >= 1 && r_lsw == 0) return 0;
		rx = pix_w();
		ry = pix_h();
		if (!width_fits(r_sw, rx) || !width_fits(r_lsw, rx)) return 0;
		total = (r_slices == 0) ? 0 : longint'(r_slices - 1) * r_sw + r_lsw;
		if (longint'(r_fh) * total < fm_cpp * rx * ry) return 0;
		if ((r_fh % fm_ys) != 0) return 0;
		if (r_fw == 0 || (r_fw % fm_xs) != 0) return 0;
		return 1;
	endfunction

	// pixel column where the current slice row starts
	function automatic longint unsigned row_start_pix();
		return longint'(gfr / pix_h()) * slice_w(0) / fm_cpp;
	endfunction

	function automatic void apply_cfg(logic [2:0] idx, logic [63:0] d);
		case (idx)
			slj_pkg::REG_FORMAT:     r_format = 32'(d[1:0]);
			slj_pkg::REG_FRAME_W:    r_fw = 32'(d[15:0]);
			slj_pkg::REG_FRAME_H:    r_fh = 32'(d[15:0]);
			slj_pkg::REG_SLICE_CNT:  r_slices = 32'(d[7:0]);
			slj_pkg::REG_SLICE_W:    r_sw = 32'(d[15:0]);
			slj_pkg::REG_LAST_W:     r_lsw = 32'(d[15:0]);
			slj_pkg::REG_IMAGE_SIZE: r_size = d[31:0];
			slj_pkg::REG_INIT_PRED:
				for (int c = 0; c < 4; c++) pred_val[c] = d[16*c +: 16];
			default: ;
		endcase
	endfunction

	// one difference in, one result out; updates predictor state
	function automatic slj_pkg::res_t recon_step(logic signed [16:0] d);
		slj_pkg::res_t r;
		longint unsigned rx, ry, pix, ppsr;
		int unsigned comp, sc, sr;
		logic [15:0] smp;
		r = '0;
		load_fmt();
		if (img_done) begin r.status = slj_pkg::ST_DONE; return r; end
		if (!geom_valid()) begin r.status = slj_pkg::ST_GEOM; return r; end
		if (g_pos >= fm_g) g_pos = 0;

		// slice-row start: bounds check and new output origin
		if (g_pos == 0 && s_col == 0) begin
			rx = pix_w();
			ry = pix_h();
			if (s_idx >= r_slices) begin
				img_done = 1; r.status = slj_pkg::ST_DONE; return r;
			end
			pix = row_start_pix();
			if (pix >= rx) begin img_done = 1; r.status = slj_pkg::ST_DONE; return r; end
			ppsr = slice_w(s_idx) / fm_cpp;
			if (pix + ppsr > rx) begin r.status = slj_pkg::ST_GEOM; return r; end
			if (s_idx + 1 == r_slices && pix + ppsr != rx) begin
				r.status = slj_pkg::ST_GEOM; return r;
			end
			img_row = 13'((gfr % ry) / fm_ys);
			img_col = 15'(pix / fm_xs * fm_cpg);
		end

		// frame-row wrap: reload from the first group of the previous row
		if (g_pos == 0 && f_col >= r_fw) begin
			for (int c = 0; c < fm_n; c++)
				pred_val[c] = row_first[c == 0 ? 0 : fm_g - (fm_n - c)];
			f_col = 0;
		end

		comp = (g_pos < fm_ppg) ? 0 : g_pos - fm_ppg + 1;
		smp = pred_val[comp] + d[15:0];
		pred_val[comp] = smp;
		if (f_col == 0) row_first[g_pos] = smp;
		r.sample  = smp;
		r.out_row = img_row;
		r.out_col = img_col + 15'(g_pos);

		g_pos++;
		if (g_pos >= fm_g) begin
			sc = s_col + fm_step;
			g_pos = 0;
			img_col = img_col + 15'(fm_g);
			f_col = (f_col + fm_xs) & 16'hFFFF;
			if (sc >= slice_w(s_idx)) begin
				sr = s_row + fm_ys;
				s_col = 0;
				gfr += fm_ys;
				if (sr >= r_fh) begin sr = 0; s_idx = (s_idx + 1) & 8'hFF; end
				s_row = sr & 16'hFFFF;
				if (s_idx >= r_slices || row_start_pix() >= pix_w()) img_done = 1;
			end else begin
				s_col = sc & 16'hFFFF;
			end
		end
		r.last = img_done;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard
	// ------------------------------------------------------------------
	slj_pkg::res_t pending_res [$];

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		slj_pkg::res_t want, got;
		if (arst_n) begin
			if (cfg_we) apply_cfg(cfg_index, cfg_data);
			if (pop && !empty) begin
				got = '{sample: sample, out_row: out_row, out_col: out_col,
					status: status, last: last};
				if (pending_res.size() == 0) begin
					report("unexpected beat, status", 32'(got.status), 32'd0);
				end else begin
					want = pending_res.pop_front();
					if (got.sample !== want.sample)
						report("sample", 32'(got.sample), 32'(want.sample));
					if (got.out_row !== want.out_row)
						report("out_row", 32'(got.out_row), 32'(want.out_row));
					if (got.out_col !== want.out_col)
						report("out_col", 32'(got.out_col), 32'(want.out_col));
					if (got.status !== want.status)
						report("status", 32'(got.status), 32'(want.status));
					if (got.last !== want.last)
						report("last", 32'(got.last), 32'(want.last));
				end
				case (got.status)
					slj_pkg::ST_OK:   n_ok++;
					slj_pkg::ST_GEOM: n_geom++;
					default:          n_done++;
				endcase
				if (got.last) n_last++;
			end
			if (push && !full) begin
				want = recon_step(difference);
				// typed rows override; predictor still advances its state
				if (pin_typed) want = pin_res;
				pending_res.push_back(want);
				n_beats_in++;
			end
		end
	end

	// watchdog: cycles with no beat and no register write
	int quiet = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_we) begin
				quiet = 0;
			end else if (++quiet >= 3000) begin
				$display("sliced_lossless_jpeg_reconstructor regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random pop, with a long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin hold_go = 0; hold_left = 90; end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (idle_mode)
					0: pop <= ($urandom_range(99, 0) >= 86);
					1: pop <= ($urandom_range(99, 0) >= 19);
					default: pop <= 1'b1;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	function automatic bit sender_idles();
		case (idle_mode)
			0: return $urandom_range(99, 0) < 19;
			1: return $urandom_range(99, 0) < 86;
			default: return 0;
		endcase
	endfunction

	task automatic send_beat(logic signed [16:0] d, bit typed, logic [1:0] st);
		if (sender_idles()) begin
			push <= 1'b0;
			do @(posedge clk); while (sender_idles());
		end
		push <= 1'b1;
		difference <= d;
		pin_typed <= typed;
		pin_res <= '{sample: 16'd0, out_row: 13'd0, out_col: 15'd0, status: st, last: 1'b0};
		do @(posedge clk); while (full);
	endtask

	task automatic drain();
		push <= 1'b0;
		// the last beat is logged by the scoreboard at its own accepting edge
		@(posedge clk);
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	// registers only change with nothing in flight
	task automatic cfg_write(logic [2:0] idx, logic [63:0] d);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		n_cfg++;
	endtask

	// valid geometry for a 24x24-pixel image cut into three 8-pixel slices
	task automatic write_geom(int mode, int fw, logic [63:0] init);
		logic [15:0] dx, dy, sw;
		case (mode)
			0: begin dx = 16'd72; dy = 16'd12; sw = 16'd24; end
			1: begin dx = 16'd48; dy = 16'd24; sw = 16'd24; end
			default: begin dx = 16'd24; dy = 16'd24; sw = 16'd8; end
		endcase
		cfg_write(slj_pkg::REG_FORMAT, 64'(mode));
		cfg_write(slj_pkg::REG_FRAME_W, 64'(fw));
		cfg_write(slj_pkg::REG_FRAME_H, 64'd24);
		cfg_write(slj_pkg::REG_SLICE_CNT, 64'd3);
		cfg_write(slj_pkg::REG_SLICE_W, 64'(sw));
		cfg_write(slj_pkg::REG_LAST_W, 64'(sw));
		cfg_write(slj_pkg::REG_IMAGE_SIZE, 64'({dy, dx}));
		cfg_write(slj_pkg::REG_INIT_PRED, init);
	endtask

	function automatic void tab_cfg(logic [2:0] idx, logic [63:0] d);
		stim_tab.push_back('{kind: ROW_CFG, idx: idx, data: d, diff: 17'sd0, typed: 1'b0,
			st: slj_pkg::ST_OK});
	endfunction

	function automatic void tab_beat(logic signed [16:0] d, bit typed, logic [1:0] st);
		stim_tab.push_back('{kind: ROW_BEAT, idx: slj_pkg::REG_FORMAT, data: 64'd0, diff: d,
			typed: typed, st: st});
	endfunction

	// bad value in one register, one beat flagged, then restore
	function automatic void tab_probe(logic [2:0] idx, logic [63:0] bad, logic [63:0] good);
		tab_cfg(idx, bad);
		tab_beat(17'sd1234, 1'b1, slj_pkg::ST_GEOM);
		tab_cfg(idx, good);
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	int mode_l [12] = '{0, 1, 2, 3, 3, 2, 1, 0, 2, 3, 0, 1};
	int fw_l   [12] = '{2, 65534, 1, 24, 65535, 8, 2, 24, 3, 1, 8, 4};

	initial begin
		logic [63:0] init;
		push = 1'b0;
		difference = '0;
		cfg_we = 1'b0;
		cfg_index = slj_pkg::REG_FORMAT;
		cfg_data = '0;
		pin_typed = 1'b0;
		pin_res = '0;
		hold_go = 0;
		idle_mode = 2;

		// predictor reset state (row store zeroed, though never read unwritten)
		r_format = 2; r_fw = 1; r_fh = 1; r_slices = 1; r_sw = 1; r_lsw = 1;
		r_size = 32'h0001_0001;
		foreach (pred_val[c]) pred_val[c] = '0;
		foreach (row_first[c]) row_first[c] = '0;
		s_idx = 0; s_row = 0; s_col = 0; f_col = 0; g_pos = 0; gfr = 0;
		img_row = '0; img_col = '0; img_done = 0;

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry (1x1, slice width not a multiple of the step) is invalid
		tab_beat(17'sd0, 1'b1, slj_pkg::ST_GEOM);
		// 3comp 2x2; the first full group fills the whole row-start store
		tab_cfg(slj_pkg::REG_FORMAT, 64'd0);
		tab_cfg(slj_pkg::REG_FRAME_W, 64'd2);
		tab_cfg(slj_pkg::REG_FRAME_H, 64'd24);
		tab_cfg(slj_pkg::REG_SLICE_CNT, 64'd3);
		tab_cfg(slj_pkg::REG_SLICE_W, 64'd24);
		tab_cfg(slj_pkg::REG_LAST_W, 64'd24);
		tab_cfg(slj_pkg::REG_IMAGE_SIZE, 64'({16'd12, 16'd72}));
		tab_cfg(slj_pkg::REG_INIT_PRED, 64'd0);
		tab_beat(-17'sd32768, 1'b0, slj_pkg::ST_OK);
		tab_beat(17'sd32767, 1'b0, slj_pkg::ST_OK);
		tab_beat(17'sd32768, 1'b0, slj_pkg::ST_OK);
		tab_beat(17'sd0, 1'b0, slj_pkg::ST_OK);
		tab_beat(17'sd1, 1'b0, slj_pkg::ST_OK);
		tab_beat(-17'sd1, 1'b0, slj_pkg::ST_OK);
		// geometry errors: each drops the beat with no state change
		tab_probe(slj_pkg::REG_IMAGE_SIZE, 64'd0, 64'({16'd12, 16'd72}));
		tab_probe(slj_pkg::REG_IMAGE_SIZE, 64'hFFFF_FFFF, 64'({16'd12, 16'd72}));
		tab_probe(slj_pkg::REG_FRAME_W, 64'd65535, 64'd2);   // odd width, horizontal factor 2
		tab_probe(slj_pkg::REG_FRAME_W, 64'd0, 64'd2);
		tab_probe(slj_pkg::REG_FRAME_H, 64'd65535, 64'd24);  // not a multiple of 2
		tab_probe(slj_pkg::REG_SLICE_W, 64'd65535, 64'd24);  // wider than the image
		tab_probe(slj_pkg::REG_LAST_W, 64'd65535, 64'd24);
		tab_probe(slj_pkg::REG_SLICE_CNT, 64'd1, 64'd3);     // slices cannot cover the image
		tab_cfg(slj_pkg::REG_SLICE_W, 64'd0);                // zero width with many slices
		tab_probe(slj_pkg::REG_SLICE_CNT, 64'd255, 64'd3);
		tab_cfg(slj_pkg::REG_SLICE_W, 64'd24);
		// predictors all ones: wrap on both sides
		tab_cfg(slj_pkg::REG_INIT_PRED, '1);
		tab_beat(17'sd1, 1'b0, slj_pkg::ST_OK);
		tab_beat(-17'sd32768, 1'b0, slj_pkg::ST_OK);
		tab_beat(17'sd32768, 1'b0, slj_pkg::ST_OK);
		tab_beat(17'sd0, 1'b0, slj_pkg::ST_OK);

		foreach (stim_tab[i]) begin
			if (stim_tab[i].kind == ROW_CFG)
				cfg_write(stim_tab[i].idx, stim_tab[i].data);
			else
				send_beat(stim_tab[i].diff, stim_tab[i].typed, stim_tab[i].st);
		end

		// random phases; format and frame width change between phases and the
		// image runs to completion partway, after which beats report done
		for (int p = 0; p < 12; p++) begin
			idle_mode = p / 4;
			case (p)
				0: init = '1;
				6: init = '0;
				default: init = {$urandom, $urandom};
			endcase
			write_geom(mode_l[p], fw_l[p], init);
			if (p == 9) hold_go = 1;   // long receiver stall while sender pushes
			for (int i = 0; i < 140; i++) begin
				if (p == 5 && i == 70) drain();   // sender pause until all back
				send_beat(17'($urandom_range(65536, 0)) - 17'sd32768, 1'b0, slj_pkg::ST_OK);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d beats in, %0d register writes, all four formats",
			n_beats_in, n_cfg);
		$display("results: %0d ok, %0d geometry errors, %0d after completion, %0d last",
			n_ok, n_geom, n_done, n_last);
		if (errors == 0 && pending_res.size() == 0)
			$display("sliced_lossless_jpeg_reconstructor regression: pass");
		else
			$display("sliced_lossless_jpeg_reconstructor regression: fail");
		$finish;
	end

endmodule
